// ===== rtl/core/thermistor_adc_to_temperature_core_defines.svh =====
// Assertion macros shared by the thermistor core checkers.
`ifndef THERMISTOR_ADC_TO_TEMPERATURE_CORE_DEFINES_SVH
`define THERMISTOR_ADC_TO_TEMPERATURE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TADC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define TADC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/tadc_pkg.sv =====
// Types, widths and lookup tables for the thermistor ADC to temperature core.
package tadc_pkg;

   localparam int ADC_W         = 12;
   localparam int TEMP_W        = 12;
   localparam int STAT_W        = 2;
   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int RES_W         = 15;   // widest table resistance, 1/16 ohm
   localparam int R_W           = 25;   // widest computed resistance, 1/16 ohm
   localparam int DVD_W         = RES_W + TEMP_W;  // divider dividend / quotient
   localparam int DVS_W         = RES_W;           // divider divisor

   localparam int REF_SCALE  = 330 * 16;  // reference ohms in 1/16 ohm
   localparam int FULL_SCALE = 4095;

   // Clamp status codes
   localparam logic [STAT_W-1:0] ST_INTERP = 2'd0;
   localparam logic [STAT_W-1:0] ST_COLD   = 2'd1;
   localparam logic [STAT_W-1:0] ST_HOT    = 2'd2;

   // Resistance in 1/16 ohm, strictly decreasing
   localparam logic [RES_W-1:0] RES_TAB [TABLE_ENTRIES] = '{
      15'd32496, 15'd20576, 15'd13502, 15'd9118, 15'd6208, 15'd4445, 15'd3200, 15'd2347,
      15'd1728,  15'd1323,  15'd1016,  15'd789,  15'd622,  15'd486,  15'd390,  15'd317
   };

   // Temperature in 1/16 degC
   localparam logic [TEMP_W-1:0] TEMP_TAB [TABLE_ENTRIES] = '{
      12'd320,  12'd480,  12'd640,  12'd800,  12'd960,  12'd1120, 12'd1280, 12'd1440,
      12'd1600, 12'd1760, 12'd1920, 12'd2080, 12'd2240, 12'd2400, 12'd2560, 12'd2720
   };

   // Divider start request
   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   // Divider result
   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== rtl/core/tadc_if.sv =====
// Valid/ready channel interfaces for ADC code words and temperature words.
interface tadc_req_if
   import tadc_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [ADC_W-1:0] adc_code;

   modport source (output valid, output adc_code, input ready);
   modport sink   (input valid, input adc_code, output ready);
endinterface

interface tadc_rsp_if
   import tadc_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [TEMP_W-1:0] temperature;
   logic [STAT_W-1:0] clamp_status;

   modport source (output valid, output temperature, output clamp_status, input ready);
   modport sink   (input valid, input temperature, input clamp_status, output ready);
endinterface

// ===== rtl/core/tadc_divider.sv =====
// Restoring serial divider, one quotient bit per cycle, shared by both divisions.
module tadc_divider
   import tadc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(DVD_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W:0]   trial;
   logic             fits;

   // One shift-subtract step
   always_comb begin
      trial   = {rem_ff, quo_ff[DVD_W-1]};
      fits    = (trial >= {1'b0, dvs_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? DVS_W'(trial - {1'b0, dvs_ff}) : trial[DVS_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== rtl/core/thermistor_adc_to_temperature_core.sv =====
// A nonzero code runs the 27-step serial divider once for the resistance and, when
// interpolating, once more for the interpolation, with a table walk of one entry per cycle.
// The core takes one word at a time; the next word is taken as the result goes valid.
// Reset (synchronous, active high) returns the sequencer to idle and empties the output.
// The result register holds a finished word while the core takes the next one.
module thermistor_adc_to_temperature_core
   import tadc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   tadc_req_if.sink          req_if,
   tadc_rsp_if.source        rsp_if
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DIV_R = 3'd1;
   localparam logic [2:0] S_WALK  = 3'd2;
   localparam logic [2:0] S_MUL   = 3'd3;
   localparam logic [2:0] S_DIV_T = 3'd4;
   localparam logic [2:0] S_FIN   = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [R_W-1:0]    r_ff, r_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [TEMP_W-1:0] t_base_ff, t_base_in;
   logic [TEMP_W-1:0] res_temp_ff, res_temp_in;
   logic [STAT_W-1:0] res_stat_ff, res_stat_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [TEMP_W-1:0] rsp_temp_ff, rsp_temp_in;
   logic [STAT_W-1:0] rsp_stat_ff, rsp_stat_in;

   div_req_type       div_req;
   div_rsp_type       div_rsp;

   logic [R_W-1:0]    span;
   logic [R_W-1:0]    num;
   logic [IDX_W-1:0]  idx_nx;
   logic [RES_W-1:0]  r1, r2;
   logic [TEMP_W-1:0] t1, t2;
   logic              seg_ok;
   logic [RES_W-1:0]  dr;
   logic [DVD_W-1:0]  prod;
   logic              accept;
   logic              out_free;

   tadc_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Scaled divider voltage and interval operands
   always_comb begin
      span   = R_W'(ADC_W'(FULL_SCALE) - req_if.adc_code);
      num    = span * R_W'(REF_SCALE);
      idx_nx = idx_ff + 1'b1;
      r1     = RES_TAB[idx_ff];
      r2     = RES_TAB[idx_nx];
      t1     = TEMP_TAB[idx_ff];
      t2     = TEMP_TAB[idx_nx];
      seg_ok = (r1 > r2) && (R_W'(r1) >= r_ff) && (t2 >= t1);
      dr     = r1 - r_ff[RES_W-1:0];
      prod   = DVD_W'(dr) * DVD_W'(t2 - t1);
   end

   assign accept   = req_if.valid && req_if.ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // Sequencer
   always_comb begin
      state_in         = state_ff;
      r_in             = r_ff;
      idx_in           = idx_ff;
      t_base_in        = t_base_ff;
      res_temp_in      = res_temp_ff;
      res_stat_in      = res_stat_ff;
      div_req.start    = 1'b0;
      div_req.dividend = DVD_W'(num);
      div_req.divisor  = DVS_W'(req_if.adc_code);
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_if.adc_code == '0) begin
                  res_temp_in = TEMP_TAB[0];
                  res_stat_in = ST_COLD;
                  state_in    = S_FIN;
               end else begin
                  div_req.start = 1'b1;
                  state_in      = S_DIV_R;
               end
            end
         end
         S_DIV_R: begin
            if (div_rsp.done) begin
               r_in   = div_rsp.quotient[R_W-1:0];
               idx_in = '0;
               if (div_rsp.quotient >= DVD_W'(RES_TAB[0])) begin
                  res_temp_in = TEMP_TAB[0];
                  res_stat_in = ST_COLD;
                  state_in    = S_FIN;
               end else if (div_rsp.quotient <= DVD_W'(RES_TAB[TABLE_ENTRIES-1])) begin
                  res_temp_in = TEMP_TAB[TABLE_ENTRIES-1];
                  res_stat_in = ST_HOT;
                  state_in    = S_FIN;
               end else begin
                  state_in = S_WALK;
               end
            end
         end
         S_WALK: begin
            // Step down the table while the resistance is below the next point
            if ((idx_ff < IDX_W'(TABLE_ENTRIES - 2)) && (r_ff < R_W'(r2))) begin
               idx_in = idx_nx;
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            t_base_in   = t1;
            res_stat_in = ST_INTERP;
            if (seg_ok) begin
               div_req.start    = 1'b1;
               div_req.dividend = prod;
               div_req.divisor  = DVS_W'(r1 - r2);
               state_in         = S_DIV_T;
            end else begin
               res_temp_in = t1;
               state_in    = S_FIN;
            end
         end
         S_DIV_T: begin
            if (div_rsp.done) begin
               res_temp_in = t_base_ff + div_rsp.quotient[TEMP_W-1:0];
               state_in    = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output word register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_temp_in  = rsp_temp_ff;
      rsp_stat_in  = rsp_stat_ff;
      if (state_ff == S_FIN && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_temp_in  = res_temp_ff;
         rsp_stat_in  = res_stat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      r_ff        <= r_in;
      idx_ff      <= idx_in;
      t_base_ff   <= t_base_in;
      res_temp_ff <= res_temp_in;
      res_stat_ff <= res_stat_in;
      rsp_temp_ff <= rsp_temp_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   assign req_if.ready        = (state_ff == S_IDLE);
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.temperature  = rsp_temp_ff;
   assign rsp_if.clamp_status = rsp_stat_ff;

endmodule

// ===== rtl/core/tadc_checker.sv =====
// Port-level checks for the thermistor core, bound to the top level.
`include "thermistor_adc_to_temperature_core_defines.svh"

module tadc_checker
   import tadc_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [TEMP_W-1:0] temperature,
   input logic [STAT_W-1:0] clamp_status
);

   // A stalled result word holds
   `TADC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(temperature) && $stable(clamp_status), "stalled result word changed")

   // The core works on one word at a time
   `TADC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "input taken while busy")

   // Cold clamp reports the cold end of the table
   `TADC_ASSERT_NOW(a_cold_value, clock, reset, rsp_valid && clamp_status == ST_COLD, temperature == TEMP_TAB[0], "cold clamp with wrong temperature")

   // Hot clamp reports the hot end of the table
   `TADC_ASSERT_NOW(a_hot_value, clock, reset, rsp_valid && clamp_status == ST_HOT, temperature == TEMP_TAB[TABLE_ENTRIES-1], "hot clamp with wrong temperature")

   // Interpolated words stay inside the table range and use a known status
   `TADC_ASSERT_NOW(a_interp_range, clock, reset, rsp_valid && clamp_status != ST_COLD && clamp_status != ST_HOT, clamp_status == ST_INTERP && temperature >= TEMP_TAB[0] && temperature <= TEMP_TAB[TABLE_ENTRIES-1], "interpolated word out of range")

endmodule

bind thermistor_adc_to_temperature_core tadc_checker u_tadc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_if.valid),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .temperature  (rsp_if.temperature),
   .clamp_status (rsp_if.clamp_status)
);

// ===== tb/sv/thermistor_adc_to_temperature_core_checker.sv =====
// Checker for the thermistor core: predicts each temperature word and compares results.
module thermistor_adc_to_temperature_core_checker
   import tadc_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   tadc_req_if    req_mon,
   tadc_rsp_if    rsp_mon,
   output int     failures,
   output int     outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [TEMP_W-1:0] temperature;
      logic [STAT_W-1:0] clamp_status;
   } temp_word_type;

   // Breakpoints of the curve: resistance in 1/16 ohm (falling), temperature in 1/16 degC
   localparam int unsigned OHMS_X16 [TABLE_ENTRIES] = '{
      32496, 20576, 13502, 9118, 6208, 4445, 3200, 2347,
      1728,  1323,  1016,  789,  622,  486,  390,  317
   };
   localparam int unsigned DEGC_X16 [TABLE_ENTRIES] = '{
      320,  480,  640,  800,  960,  1120, 1280, 1440,
      1600, 1760, 1920, 2080, 2240, 2400, 2560, 2720
   };

   temp_word_type expected_temps [$];
   int            error_count = 0;

   assign failures    = error_count;
   assign outstanding = expected_temps.size();

   // ADC code -> divider resistance -> clamped or interpolated temperature
   function automatic temp_word_type convert_code(input logic [ADC_W-1:0] code);
      temp_word_type w;
      int unsigned   ohms;
      int unsigned   seg;
      int unsigned   r1, r2, t1, t2;
      if (code == '0) begin
         // open divider reads as unbounded resistance
         w.temperature  = TEMP_W'(DEGC_X16[0]);
         w.clamp_status = ST_COLD;
         return w;
      end
      ohms = (32'(REF_SCALE) * (32'(FULL_SCALE) - 32'(code))) / 32'(code);
      if (ohms >= OHMS_X16[0]) begin
         w.temperature  = TEMP_W'(DEGC_X16[0]);
         w.clamp_status = ST_COLD;
      end else if (ohms <= OHMS_X16[TABLE_ENTRIES-1]) begin
         w.temperature  = TEMP_W'(DEGC_X16[TABLE_ENTRIES-1]);
         w.clamp_status = ST_HOT;
      end else begin
         // walk to the interval whose lower end is at or below the resistance
         seg = 0;
         while (seg < TABLE_ENTRIES - 2 && ohms < OHMS_X16[seg+1])
            seg++;
         r1 = OHMS_X16[seg];
         r2 = OHMS_X16[seg+1];
         t1 = DEGC_X16[seg];
         t2 = DEGC_X16[seg+1];
         if (r1 > r2 && r1 >= ohms && t2 >= t1)
            w.temperature = TEMP_W'(t1 + ((r1 - ohms) * (t2 - t1)) / (r1 - r2));
         else
            w.temperature = TEMP_W'(t1);
         w.clamp_status = ST_INTERP;
      end
      return w;
   endfunction

   task automatic report(input string msg);
      $display("ERROR %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Pop on each accepted result word first, then queue the prediction for an accepted code
   always @(posedge clock) begin
      temp_word_type want;
      if (!reset) begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_temps.size() == 0) begin
               report($sformatf("unexpected result word temp=%0d status=%0d",
                                rsp_mon.temperature, rsp_mon.clamp_status));
            end else begin
               want = expected_temps.pop_front();
               if (rsp_mon.temperature !== want.temperature)
                  report($sformatf("temperature %0d, expected %0d",
                                   rsp_mon.temperature, want.temperature));
               if (rsp_mon.clamp_status !== want.clamp_status)
                  report($sformatf("clamp_status %0d, expected %0d",
                                   rsp_mon.clamp_status, want.clamp_status));
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_temps.push_back(convert_code(req_mon.adc_code));
      end
   end

endmodule

// ===== tb/sv/thermistor_adc_to_temperature_core_tb.sv =====
// Testbench top for the thermistor core: clock, reset, code stimulus, result stalls and verdict.
module thermistor_adc_to_temperature_core_tb
   import tadc_pkg::*;
   ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_CODES   = 1200;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int DRAIN_CYCLES   = 100;
   localparam int LONG_HOLD      = 600;
   localparam int DIVIDER_PRODUCT = REF_SCALE * FULL_SCALE;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   failures;
   int   outstanding;
   int   cycle_count = 0;
   bit   hold_rsp = 1'b0;

   tadc_req_if req_if ();
   tadc_rsp_if rsp_if ();

   thermistor_adc_to_temperature_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   thermistor_adc_to_temperature_core_checker chk (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .failures    (failures),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Code that lands on or just past a breakpoint of the curve
   function automatic logic [ADC_W-1:0] code_near_point(input int k);
      return ADC_W'(DIVIDER_PRODUCT / (int'(RES_TAB[k]) + REF_SCALE));
   endfunction

   // Offer one code word after a random gap (none when quiet), hold until accepted
   task automatic send_code(input logic [ADC_W-1:0] code, input bit quiet);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.adc_code <= code;
      @(posedge clock);
      while (!(req_if.valid && req_if.ready)) @(posedge clock);
   endtask

   // Result side: random stall per word, bursts without stalls, one long hold-off
   initial begin
      int  gap;
      int  words;
      bit  quiet;
      words = 0;
      quiet = 1'b0;
      rsp_if.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (words % 100 == 0)
            quiet = ($urandom_range(0, 3) == 0);
         gap = quiet ? 0 : $urandom_range(0, 5);
         if (hold_rsp) begin
            gap      = LONG_HOLD;
            hold_rsp = 1'b0;
         end
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_if.valid && rsp_if.ready)) @(posedge clock);
         words++;
      end
   end

   // Code stimulus and verdict
   initial begin
      logic [ADC_W-1:0] code;
      int               sel;
      int               k;
      bit               quiet;
      req_if.valid    <= 1'b0;
      req_if.adc_code <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: open input, full scale, bit patterns, each breakpoint
      send_code(12'd0, 1'b0);
      send_code(12'd1, 1'b0);
      send_code(12'd4095, 1'b0);
      send_code(12'd4094, 1'b1);
      send_code(12'hAAA, 1'b0);
      send_code(12'h555, 1'b1);
      send_code(12'h800, 1'b0);
      send_code(12'h7FF, 1'b0);
      for (k = 0; k < TABLE_ENTRIES; k++)
         send_code(code_near_point(k), k[0]);

      // Random: mostly the interpolated range, plus clamps, breakpoints and full range
      quiet = 1'b0;
      for (int n = 0; n < RANDOM_CODES; n++) begin
         if (n % 150 == 0)
            quiet = ($urandom_range(0, 2) == 0);
         if (n == 400)
            hold_rsp = 1'b1;
         sel = $urandom_range(0, 9);
         if (sel == 0)
            code = ADC_W'($urandom_range(0, 4095));
         else if (sel <= 5)
            code = ADC_W'($urandom_range(573, 3862));
         else if (sel == 6)
            code = ADC_W'($urandom_range(0, 600));
         else if (sel == 7)
            code = ADC_W'($urandom_range(3850, 4095));
         else begin
            k    = $urandom_range(0, TABLE_ENTRIES - 1);
            code = code_near_point(k) + ADC_W'($urandom_range(0, 2)) - 12'd1;
         end
         send_code(code, quiet);
      end
      req_if.valid <= 1'b0;

      // Drain, then let the core settle
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && outstanding == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
